>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the value adjust block.
// Needs a clk and an rst_n signal in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define HVA_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checked at every edge, reset included.
`define HVA_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

>>> rtl/core/hva_pkg.sv
// Package for the value adjust block: widths and the pipeline stage record.
// No dependencies.
`default_nettype none
package hva_pkg;
  localparam int COMPONENT_BITS = 8;
  localparam int CW      = COMPONENT_BITS;
  localparam int DW      = COMPONENT_BITS + 1;       // value_delta width
  localparam int NW      = 2 * COMPONENT_BITS + 1;   // dividend and remainder width
  localparam int NST     = (COMPONENT_BITS + 1) / 2; // divider stages, two quotient bits each
  localparam int IN_W    = 3 * CW + DW;
  localparam int IN_TW   = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W   = 3 * CW;
  localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

  typedef struct packed {
    logic                   valid;
    logic                   grey;
    logic [CW-1:0]          v;
    logic [CW:0]            d;   // twice the input maximum
    logic [2:0][NW-1:0]     n;   // remainders, red in entry 0
    logic [2:0][CW-1:0]     q;   // quotients built so far
  } stage_t;
endpackage
`default_nettype wire

>>> rtl/core/hsv_value_adjust.sv
// Top level of the HSV value adjust block: front stage and pipelined divider.
// Depends on hva_pkg and assert_macros.svh.
//
//   channel  direction  tdata fields (low bit up)          tuser/tlast
//   in_      slave      red, green, blue, value_delta      none
//   out_     master     red, green, blue                   none
//
// One pixel per cycle while the output is not stalled.
// The depth is set by the restoring divider, two quotient bits per stage.
// Reset clears only the valid bits; the pipeline holds no state between pixels.
// A stall at the output freezes every stage, so nothing is lost or repeated.
`default_nettype none
`include "assert_macros.svh"
module hsv_value_adjust
  import hva_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output      logic              in_tready,
  input  wire logic [IN_TW-1:0]  in_tdata,   // red_in, green_in, blue_in, value_delta
  output      logic              out_tvalid,
  input  wire logic              out_tready,
  output      logic [OUT_TW-1:0] out_tdata   // red_out, green_out, blue_out
);

  stage_t st_r   [0:NST];
  stage_t st_nxt [0:NST];
  logic   adv;

  assign adv       = !st_r[NST].valid || out_tready;
  assign in_tready = adv;

  // Front stage: max, min, new value and the products c * V.
  always_comb begin
    logic [CW-1:0]        c [3];
    logic signed [DW:0]   vsum;
    logic [CW-1:0]        mx;
    logic [CW-1:0]        mn;
    logic [CW-1:0]        v;
    logic [2*CW-1:0]      prod;
    c[0] = in_tdata[CW-1:0];
    c[1] = in_tdata[2*CW-1:CW];
    c[2] = in_tdata[3*CW-1:2*CW];
    mx = (c[0] > c[1]) ? c[0] : c[1];
    if (c[2] > mx) begin
      mx = c[2];
    end
    mn = (c[0] < c[1]) ? c[0] : c[1];
    if (c[2] < mn) begin
      mn = c[2];
    end
    vsum = $signed({2'b00, mx}) + $signed({in_tdata[IN_W-1], in_tdata[IN_W-1:3*CW]});
    if (vsum < 0) begin
      v = '0;
    end else if (vsum > $signed({2'b00, {CW{1'b1}}})) begin
      v = {CW{1'b1}};
    end else begin
      v = vsum[CW-1:0];
    end
    st_nxt[0].valid = in_tvalid;
    st_nxt[0].grey  = (mx == mn);
    st_nxt[0].v     = v;
    st_nxt[0].d     = {mx, 1'b0};
    st_nxt[0].q     = '0;
    for (int i = 0; i < 3; i++) begin
      prod = c[i] * v;
      // Dividend 2cV + M gives round-half-up after division by 2M.
      st_nxt[0].n[i] = {prod, 1'b0} + NW'(mx);
    end
  end

  for (genvar s = 1; s <= NST; s++) begin : g_div
    always_comb begin
      stage_t          t;
      int              k;
      logic [NW-1:0]   sub;
      t = st_r[s-1];
      for (int j = 0; j < 2; j++) begin
        k = CW - 1 - (2 * (s - 1) + j);
        if (k >= 0) begin
          sub = NW'(t.d) << k;
          for (int i = 0; i < 3; i++) begin
            if (t.n[i] >= sub) begin
              t.n[i] = t.n[i] - sub;
              t.q[i] = t.q[i] | (CW'(1) << k);
            end
          end
        end
      end
      st_nxt[s] = t;
    end
  end

  for (genvar s = 0; s <= NST; s++) begin : g_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[s].valid <= 1'b0;
      end else if (adv) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign out_tvalid = st_r[NST].valid;
  always_comb begin
    out_tdata = '0;
    if (st_r[NST].grey) begin
      out_tdata[OUT_W-1:0] = {3{st_r[NST].v}};
    end else begin
      out_tdata[OUT_W-1:0] = {st_r[NST].q[2], st_r[NST].q[1], st_r[NST].q[0]};
    end
  end

  `HVA_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "output valid right after reset")
  `HVA_ASSERT(a_div_done, (out_tvalid && !st_r[NST].grey) |-> (st_r[NST].n[0] < NW'(st_r[NST].d) && st_r[NST].n[1] < NW'(st_r[NST].d) && st_r[NST].n[2] < NW'(st_r[NST].d)), "division left a remainder too large")
  `HVA_ASSERT(a_max_is_v, (out_tvalid && !st_r[NST].grey) |-> (st_r[NST].q[0] <= st_r[NST].v && st_r[NST].q[1] <= st_r[NST].v && st_r[NST].q[2] <= st_r[NST].v), "channel exceeds new value")

endmodule
`default_nettype wire

>>> verif/hsv_value_adjust_checker.sv
// Checker for the HSV value adjust block: watches both stream channels,
// predicts each adjusted pixel and compares it field by field.
// Depends on hva_pkg.
`timescale 1ns / 1ps
module hsv_value_adjust_checker
  import hva_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_tready,
  input  wire logic [IN_TW-1:0]  in_tdata,
  input  wire logic              out_tvalid,
  input  wire logic              out_tready,
  input  wire logic [OUT_TW-1:0] out_tdata,
  output int                     fail_count,
  output int                     pending_count
);
  typedef struct packed {
    logic [CW-1:0] blue;
    logic [CW-1:0] green;
    logic [CW-1:0] red;
  } pixel_t;

  pixel_t expected_pixels[$];
  int     mismatch_count = 0;

  function automatic logic [CW-1:0] scale_component(int unsigned c, int unsigned v,
                                                   int unsigned m);
    return CW'((2 * c * v + m) / (2 * m));
  endfunction

  function automatic pixel_t adjust_pixel(logic [IN_TW-1:0] word);
    int unsigned r, g, b, mx, mn, v;
    int          delta, vsum;
    pixel_t      p;
    r = 32'(word[CW-1:0]);
    g = 32'(word[2*CW-1:CW]);
    b = 32'(word[3*CW-1:2*CW]);
    delta = int'($signed(word[3*CW+DW-1:3*CW]));
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    vsum = int'(mx) + delta;
    if (vsum < 0) vsum = 0;
    if (vsum > (1 << CW) - 1) vsum = (1 << CW) - 1;
    v = $unsigned(vsum);
    if (mx == mn) begin
      p.red = CW'(v); p.green = CW'(v); p.blue = CW'(v);
    end else begin
      p.red   = scale_component(r, v, mx);
      p.green = scale_component(g, v, mx);
      p.blue  = scale_component(b, v, mx);
    end
    return p;
  endfunction

  assign pending_count = expected_pixels.size();

  always @(posedge clk) begin
    pixel_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_pixels.push_back(adjust_pixel(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[OUT_W-1:0];
        if (expected_pixels.size() == 0) begin
          fail_count <= fail_count + 1;
          $display("unexpected output transaction %h", got);
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       want.red, want.green, want.blue, got.red, got.green, got.blue);
          end
        end
      end
    end
  end

  initial fail_count = 0;
endmodule

>>> verif/hsv_value_adjust_tb.sv
// Testbench top for the HSV value adjust block: drives pixels with random
// gaps and output stalls, and reports the checker's verdict.
// Depends on hva_pkg, hsv_value_adjust and hsv_value_adjust_checker.
`timescale 1ns / 1ps
module hsv_value_adjust_tb;
  import hva_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 200000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_TW-1:0]  in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_TW-1:0] out_tdata;
  int                fail_count, pending_count;
  int                cycle_count = 0;
  bit                quiet_phase = 1'b0;
  bit                long_hold = 1'b0;
  int                sent_count = 0;

  always #6 clk = ~clk;

  hsv_value_adjust i_dut (.*);

  hsv_value_adjust_checker i_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off, none in the quiet phase.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (40) @(negedge clk);
        long_hold = 1'b0;
        out_tready <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 4);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(logic [CW-1:0] r, logic [CW-1:0] g, logic [CW-1:0] b,
                            logic [DW-1:0] delta);
    int gap;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= IN_TW'({delta, b, g, r});
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  initial begin
    logic [CW-1:0] r, g, b;
    logic [DW-1:0] delta;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Extremes, greys including black, the lowest offset, clamping both ways.
    send_pixel(8'd0, 8'd0, 8'd0, 9'd0);
    send_pixel(8'd0, 8'd0, 8'd0, 9'd255);
    send_pixel(8'd255, 8'd255, 8'd255, 9'd255);
    send_pixel(8'd128, 8'd128, 8'd128, -9'sd255);
    send_pixel(8'd100, 8'd100, 8'd100, 9'h100);
    send_pixel(8'd255, 8'd0, 8'd0, 9'h100);
    send_pixel(8'd255, 8'd0, 8'd0, -9'sd1);
    send_pixel(8'd0, 8'd255, 8'd0, -9'sd128);
    send_pixel(8'd0, 8'd0, 8'd255, 9'd10);
    send_pixel(8'd1, 8'd2, 8'd3, 9'd255);
    send_pixel(8'd200, 8'd100, 8'd50, 9'd55);
    send_pixel(8'd200, 8'd100, 8'd50, 9'd56);
    send_pixel(8'd255, 8'd254, 8'd1, -9'sd254);
    send_pixel(8'd3, 8'd1, 8'd2, 9'd1);
    send_pixel(8'd1, 8'd0, 8'd0, 9'd254);
    send_pixel(8'd170, 8'd85, 8'd255, 9'd0);
    wait_drained();

    // The sender keeps offering while the receiver holds off for a long stretch.
    long_hold = 1'b1;
    for (int i = 0; i < 20; i++)
      send_pixel(CW'($urandom), CW'($urandom), CW'($urandom), DW'($urandom));
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - 80) quiet_phase = 1'b1;
      r = CW'($urandom); g = CW'($urandom); b = CW'($urandom); delta = DW'($urandom);
      case ($urandom_range(0, 5))
        0: begin g = r; b = r; end
        1: delta = $urandom_range(0, 1) ? 9'h100 : 9'h0ff;
        2: begin r = CW'($urandom_range(0, 3)); g = CW'($urandom_range(0, 3)); end
        default: ;
      endcase
      send_pixel(r, g, b, delta);
    end
    wait_drained();
    repeat (10) @(negedge clk);

    $display("Covered %0d pixels: greys, clamping at both ends, full-range offsets,",
             sent_count);
    $display("random gaps, output stalls and one long back-pressure stretch.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
